### rtl/fic_pkg.sv
// Shared types, register indexes and codes for the clamped first-order IIR filter.
`timescale 1ns / 1ps

package fic_pkg;

	// Fixed field widths of the words
	localparam int SAMPLE_WIDTH      = 32;
	localparam int COEFF_WIDTH       = 32;
	localparam int CFG_DATA_WIDTH    = 32;
	localparam int CFG_INDEX_WIDTH   = 3;
	localparam int CLAMP_WIDTH       = 2;
	localparam int DEF_COEFF_FRAC    = 24;

	// Configuration register indexes
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COEFF_NOW      = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COEFF_PREV_IN  = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COEFF_PREV_OUT = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OUT_MIN        = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OUT_MAX        = 3'd4;

	// Request kinds
	localparam logic REQ_FILTER = 1'b0;
	localparam logic REQ_PRESET = 1'b1;

	// Clamp status codes
	localparam logic [CLAMP_WIDTH-1:0] CLAMP_NONE = 2'd0;
	localparam logic [CLAMP_WIDTH-1:0] CLAMP_MAX  = 2'd1;
	localparam logic [CLAMP_WIDTH-1:0] CLAMP_MIN  = 2'd2;

	// Range limits of a sample
	localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	// Request word
	typedef struct packed {
		logic                           req_type;
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           new_step;
		logic signed [SAMPLE_WIDTH-1:0] preset_input;
		logic signed [SAMPLE_WIDTH-1:0] preset_output;
	} req_t;

	// Response word
	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] filtered;
		logic [CLAMP_WIDTH-1:0]         clamp_state;
	} rsp_t;

	// Programmed coefficients and limits
	typedef struct packed {
		logic signed [COEFF_WIDTH-1:0]  coeff_now;
		logic signed [COEFF_WIDTH-1:0]  coeff_prev_in;
		logic signed [COEFF_WIDTH-1:0]  coeff_prev_out;
		logic signed [SAMPLE_WIDTH-1:0] out_min;
		logic signed [SAMPLE_WIDTH-1:0] out_max;
	} cfg_t;

	// Filter delay state plus held clamp status
	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] prev_input;
		logic signed [SAMPLE_WIDTH-1:0] prev_output;
		logic [CLAMP_WIDTH-1:0]         clamp_state;
	} state_t;

endpackage

### rtl/fic_calc.sv
// Next-state logic: three products, rounding, saturation and output clamp.
`timescale 1ns / 1ps

module fic_calc #(
	parameter int COEFF_FRAC_BITS = fic_pkg::DEF_COEFF_FRAC
) (
	input  fic_pkg::req_t   req,
	input  fic_pkg::cfg_t   cfg,
	input  fic_pkg::state_t cur,
	output fic_pkg::state_t nxt
);
	import fic_pkg::*;

	localparam int PROD_W = COEFF_WIDTH + SAMPLE_WIDTH;
	localparam int ACC_W  = PROD_W + 2;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(66'd1 << (COEFF_FRAC_BITS - 1));

	logic signed [PROD_W-1:0]       prod_now;
	logic signed [PROD_W-1:0]       prod_prev_in;
	logic signed [PROD_W-1:0]       prod_prev_out;
	logic signed [ACC_W-1:0]        acc;
	logic signed [ACC_W-1:0]        acc_shr;
	logic [ACC_W-SAMPLE_WIDTH:0]    acc_top;
	logic signed [SAMPLE_WIDTH-1:0] y_sat;

	// Three independent products, all exact
	assign prod_now      = cfg.coeff_now * req.sample;
	assign prod_prev_in  = cfg.coeff_prev_in * cur.prev_input;
	assign prod_prev_out = cfg.coeff_prev_out * cur.prev_output;

	// Exact sum, round half up, drop fraction bits
	assign acc     = ACC_W'(prod_now) + ACC_W'(prod_prev_in) - ACC_W'(prod_prev_out) + HALF;
	assign acc_shr = acc >>> COEFF_FRAC_BITS;
	assign acc_top = acc_shr[ACC_W-1:SAMPLE_WIDTH-1];

	// Saturate to sample range
	always_comb begin
		if (acc_top == '0 || acc_top == '1) begin
			y_sat = acc_shr[SAMPLE_WIDTH-1:0];
		end else if (acc_shr[ACC_W-1]) begin
			y_sat = SAMPLE_MIN;
		end else begin
			y_sat = SAMPLE_MAX;
		end
	end

	// Select preset, held value or clamped filter result
	always_comb begin
		nxt = cur;
		if (req.req_type == REQ_PRESET) begin
			nxt.prev_input  = req.preset_input;
			nxt.prev_output = req.preset_output;
			nxt.clamp_state = CLAMP_NONE;
		end else if (req.new_step) begin
			if (y_sat > cfg.out_max) begin
				nxt.prev_input  = cfg.out_max;
				nxt.prev_output = cfg.out_max;
				nxt.clamp_state = CLAMP_MAX;
			end else if (y_sat < cfg.out_min) begin
				nxt.prev_input  = cfg.out_min;
				nxt.prev_output = cfg.out_min;
				nxt.clamp_state = CLAMP_MIN;
			end else begin
				nxt.prev_input  = req.sample;
				nxt.prev_output = y_sat;
				nxt.clamp_state = CLAMP_NONE;
			end
		end
	end

endmodule

### rtl/first_order_iir_clamped.sv
// Top level of the clamped first-order IIR filter: word registers, config and state.
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+--------------------
//   req     | in        | req_valid / req_stall   | fic_pkg::req_t
//   rsp     | out       | rsp_valid / rsp_stall   | fic_pkg::rsp_t
//   cfg     | in        | cfg_we (no handshake)   | cfg_index, cfg_data
//
// One word per cycle sustained while rsp_stall is low; each request gives exactly
// one response word. A request passes an input register, then the multiply-add-clamp
// into the response register; the delay-state update sets the rate.
// Reset clears config to defaults, delay state and held clamp status to zero.
// A stalled response register holds the input register; req_stall rises only
// when both are full.
`timescale 1ns / 1ps

module first_order_iir_clamped #(
	parameter int COEFF_FRAC_BITS = fic_pkg::DEF_COEFF_FRAC
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   req_valid,
	output logic                                   req_stall,
	input  fic_pkg::req_t                          req,
	output logic                                   rsp_valid,
	input  logic                                   rsp_stall,
	output fic_pkg::rsp_t                          rsp,
	input  logic                                   cfg_we,
	input  logic [fic_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  logic [fic_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);
	import fic_pkg::*;

	logic   s1_valid_s1;
	req_t   req_s1;
	logic   rsp_valid_q;
	rsp_t   rsp_q;
	cfg_t   cfg_q;
	state_t state_q;
	state_t state_nxt;
	logic   advance;
	logic   req_take;

	// Handshake
	assign advance   = s1_valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = s1_valid_s1 && !advance;
	assign req_take  = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Next state from the registered request
	fic_calc #(
		.COEFF_FRAC_BITS(COEFF_FRAC_BITS)
	) u_calc (
		.req(req_s1),
		.cfg(cfg_q),
		.cur(state_q),
		.nxt(state_nxt)
	);

	// Control, config and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1                <= 1'b0;
			rsp_valid_q                <= 1'b0;
			cfg_q.coeff_now            <= '0;
			cfg_q.coeff_prev_in        <= '0;
			cfg_q.coeff_prev_out       <= '0;
			cfg_q.out_min              <= SAMPLE_MIN;
			cfg_q.out_max              <= SAMPLE_MAX;
			state_q.prev_input         <= '0;
			state_q.prev_output        <= '0;
			state_q.clamp_state        <= CLAMP_NONE;
		end else begin
			if (req_take) begin
				s1_valid_s1 <= 1'b1;
			end else if (advance) begin
				s1_valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
				state_q     <= state_nxt;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_COEFF_NOW:      cfg_q.coeff_now      <= cfg_data[COEFF_WIDTH-1:0];
					CFG_COEFF_PREV_IN:  cfg_q.coeff_prev_in  <= cfg_data[COEFF_WIDTH-1:0];
					CFG_COEFF_PREV_OUT: cfg_q.coeff_prev_out <= cfg_data[COEFF_WIDTH-1:0];
					CFG_OUT_MIN:        cfg_q.out_min        <= cfg_data[SAMPLE_WIDTH-1:0];
					CFG_OUT_MAX:        cfg_q.out_max        <= cfg_data[SAMPLE_WIDTH-1:0];
					default: ;
				endcase
			end
		end
	end

	// Word registers
	always_ff @(posedge clk) begin
		if (req_take) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_q.filtered    <= state_nxt.prev_output;
			rsp_q.clamp_state <= state_nxt.clamp_state;
		end
	end

`ifndef SYNTHESIS
	// Response word mirrors the latest delay state
	a_rsp_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.filtered == state_q.prev_output &&
			rsp_q.clamp_state == state_q.clamp_state))
		else $error("response word differs from held filter state");

	// A clamp loads both delay registers with the limit
	a_clamp_loads_both: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.clamp_state == CLAMP_MAX || state_q.clamp_state == CLAMP_MIN) |->
			state_q.prev_input == state_q.prev_output)
		else $error("clamp left delay registers unequal");

	// A repeat call leaves the state alone
	a_repeat_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && req_s1.req_type == REQ_FILTER && !req_s1.new_step) |=>
			$stable(state_q))
		else $error("repeat call changed filter state");

	// Held word moves on when the response side is free
	a_advance_free: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && !rsp_valid_q) |=> rsp_valid_q)
		else $error("input register did not advance into free response register");
`endif

endmodule
